FILE: hdl/lrast_pkg.sv
// Shared constants and codes for the line rasterizer.
package lrast_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int REG_W          = 11;
    localparam int CFG_IDX_W      = 2;

    localparam logic [REG_W-1:0] SCREEN_W_RST = 11'd240;
    localparam logic [REG_W-1:0] SCREEN_H_RST = 11'd320;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // two's complement step direction
    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_POS  = 2'b01,
        DIR_NEG  = 2'b11
    } dir_t;

endpackage

FILE: hdl/line_rasterizer_unit.sv
// Line rasterizer top level: incremental line point generator with stream ports.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    tdata: x_start,y_start,x_end,y_end; tuser: action
//  m_        out  m_tvalid/m_tready    tdata: pixel_x,pixel_y; tuser: on_screen; tlast: last
//  cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data (screen width / height)
//
// One word is accepted per clock while s_tready is high; a step word taken
// while a line is active yields its point in the next cycle from the output
// register, fed by the err/position update. Reset is synchronous on aresetn low and
// leaves the block idle with width 240, height 320. s_tready drops only while
// a point sits in the output register and m_tready is low. cfg_ready is always high.
module line_rasterizer_unit
    import lrast_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // x_start, y_start, x_end, y_end, zero fill
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // action
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_x, pixel_y, zero fill
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // on_screen
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [REG_W-1:0]              cfg_data
);

    localparam int CB     = COORD_BITS;
    localparam int M_W    = ((2*CB+7)/8)*8;
    localparam int ERR_W  = CB + 1;
    localparam int CNT_W  = CB + 1;
    localparam int CMP_W  = (CB + 1 > REG_W) ? CB + 1 : REG_W;

    logic [REG_W-1:0] width_reg, height_reg;

    logic [CB-1:0]    cur_x_reg, cur_y_reg, cur_x_next, cur_y_next;
    logic [ERR_W-1:0] err_x_reg, err_y_reg, err_x_next, err_y_next;
    logic [CB-1:0]    abs_dx_reg, abs_dy_reg, abs_dx_next, abs_dy_next;
    logic [CB-1:0]    major_reg, major_next;
    dir_t             dir_x_reg, dir_y_reg, dir_x_next, dir_y_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             active_reg, active_next;

    logic             m_valid_reg, m_valid_next;
    logic [CB-1:0]    px_reg, py_reg;
    logic             on_reg, last_reg;

    logic             s_accept, emit;
    logic [CB-1:0]    xs, ys, xe, ye;
    logic [ERR_W-1:0] sum_x, sum_y;
    logic             on_screen;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign emit      = s_accept && (s_tuser == ACT_STEP) && active_reg;
    assign cfg_ready = 1'b1;

    assign xs = s_tdata[CB-1:0];
    assign ys = s_tdata[2*CB-1:CB];
    assign xe = s_tdata[3*CB-1:2*CB];
    assign ye = s_tdata[4*CB-1:3*CB];

    assign on_screen = (CMP_W'(cur_x_reg) < CMP_W'(width_reg)) &&
                       (CMP_W'(cur_y_reg) < CMP_W'(height_reg));

    assign sum_x = err_x_reg + ERR_W'(abs_dx_reg);
    assign sum_y = err_y_reg + ERR_W'(abs_dy_reg);

    function automatic logic [CB-1:0] axis_move(input logic [CB-1:0] pos, input dir_t dir);
        logic [CB-1:0] res;
        case (dir)
            DIR_POS: res = pos + CB'(1);
            DIR_NEG: res = pos - CB'(1);
            default: res = pos;
        endcase
        return res;
    endfunction

    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_x_next  = err_x_reg;
        err_y_next  = err_y_reg;
        abs_dx_next = abs_dx_reg;
        abs_dy_next = abs_dy_reg;
        major_next  = major_reg;
        dir_x_next  = dir_x_reg;
        dir_y_next  = dir_y_reg;
        left_next   = left_reg;
        active_next = active_reg;

        if (s_accept && s_tuser == ACT_LOAD) begin
            if (xe > xs) begin
                abs_dx_next = xe - xs;
                dir_x_next  = DIR_POS;
            end else if (xe == xs) begin
                abs_dx_next = '0;
                dir_x_next  = DIR_NONE;
            end else begin
                abs_dx_next = xs - xe;
                dir_x_next  = DIR_NEG;
            end
            if (ye > ys) begin
                abs_dy_next = ye - ys;
                dir_y_next  = DIR_POS;
            end else if (ye == ys) begin
                abs_dy_next = '0;
                dir_y_next  = DIR_NONE;
            end else begin
                abs_dy_next = ys - ye;
                dir_y_next  = DIR_NEG;
            end
            major_next  = (abs_dx_next > abs_dy_next) ? abs_dx_next : abs_dy_next;
            cur_x_next  = xs;
            cur_y_next  = ys;
            err_x_next  = '0;
            err_y_next  = '0;
            left_next   = CNT_W'(major_next) + CNT_W'(2);
            active_next = 1'b1;
        end else if (emit) begin
            err_x_next = sum_x;
            err_y_next = sum_y;
            if (sum_x > ERR_W'(major_reg)) begin
                err_x_next = sum_x - ERR_W'(major_reg);
                cur_x_next = axis_move(cur_x_reg, dir_x_reg);
            end
            if (sum_y > ERR_W'(major_reg)) begin
                err_y_next = sum_y - ERR_W'(major_reg);
                cur_y_next = axis_move(cur_y_reg, dir_y_reg);
            end
            left_next = left_reg - CNT_W'(1);
            if (left_reg == CNT_W'(1))
                active_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= SCREEN_W_RST;
            height_reg  <= SCREEN_H_RST;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            err_x_reg   <= '0;
            err_y_reg   <= '0;
            abs_dx_reg  <= '0;
            abs_dy_reg  <= '0;
            major_reg   <= '0;
            dir_x_reg   <= DIR_NONE;
            dir_y_reg   <= DIR_NONE;
            left_reg    <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SCREEN_WIDTH)
                    width_reg <= cfg_data;
                else if (cfg_index == CFG_SCREEN_HEIGHT)
                    height_reg <= cfg_data;
            end
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            err_x_reg   <= err_x_next;
            err_y_reg   <= err_y_next;
            abs_dx_reg  <= abs_dx_next;
            abs_dy_reg  <= abs_dy_next;
            major_reg   <= major_next;
            dir_x_reg   <= dir_x_next;
            dir_y_reg   <= dir_y_next;
            left_reg    <= left_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output word payload, loaded only with a new point
    always_ff @(posedge aclk) begin
        if (emit) begin
            px_reg   <= cur_x_reg;
            py_reg   <= cur_y_reg;
            on_reg   <= on_screen;
            last_reg <= (left_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_W'({py_reg, px_reg});
    assign m_tuser  = on_reg;
    assign m_tlast  = last_reg;

    // error terms never exceed the major length between steps
    a_err_x_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        err_x_reg <= ERR_W'(major_reg))
        else $error("err_x above major length");

    a_err_y_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        err_y_reg <= ERR_W'(major_reg))
        else $error("err_y above major length");

    // point count is zero exactly when idle
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg == (left_reg != '0))
        else $error("point count out of step with active flag");

    // the point flagged last sends the block idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && left_reg == CNT_W'(1)) |=> (!active_reg && m_tvalid && m_tlast))
        else $error("last point did not end the line");

endmodule
